FILE: rtl/core/ps2m_pkg.sv
package ps2m_pkg;

    // Event codes carried on the input opcode field
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_BYTE    = 2'd1,
        OP_RESTART = 2'd2,
        OP_IGNORED = 2'd3
    } t_opcode;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_WHEEL_ENABLE   = 2'd0,
        CFG_INIT_TIMEOUT   = 2'd1,
        CFG_PACKET_TIMEOUT = 2'd2
    } t_cfg_index;

    // Controller phase
    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_SCRIPT = 2'd1,
        PH_RUN    = 2'd2
    } t_phase;

    localparam int unsigned PTR_W          = 5;
    localparam int unsigned SEND_W         = 4;
    localparam int unsigned AWAIT_W        = 7;
    localparam int unsigned TIMER_W        = 16;
    localparam int unsigned PIDX_W         = 3;
    localparam int unsigned CFG_W          = 16;
    localparam int unsigned SCRIPT_DEPTH   = 16;

    localparam logic [TIMER_W-1:0] INIT_TIMEOUT_RST   = 16'd3500;
    localparam logic [TIMER_W-1:0] PACKET_TIMEOUT_RST = 16'd500;

    // Mouse command bytes
    localparam logic [7:0] CMD_RESET    = 8'hFF;
    localparam logic [7:0] CMD_ENABLE   = 8'hF4;
    localparam logic [7:0] CMD_SET_RATE = 8'hF3;
    localparam logic [7:0] CMD_GET_ID   = 8'hF2;
    localparam logic [7:0] RATE_200     = 8'd200;
    localparam logic [7:0] RATE_100     = 8'd100;
    localparam logic [7:0] RATE_80      = 8'd80;

    // Script entry kinds: top bit set awaits replies, else sends bytes
    localparam logic [7:0] AWAIT_FLAG   = 8'h80;
    localparam logic [7:0] ENTRY_END    = 8'h00;
    localparam logic [7:0] SEND_ONE     = 8'h01;
    localparam logic [7:0] SEND_KNOCK   = 8'h07;
    localparam logic [7:0] AWAIT_ONE    = AWAIT_FLAG | 8'h01;
    localparam logic [7:0] AWAIT_TWO    = AWAIT_FLAG | 8'h02;

    typedef struct packed {
        t_phase               phase;
        logic [SEND_W-1:0]    send;
        logic [AWAIT_W-1:0]   awt;
    } t_load;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       packet_valid;
        logic [7:0] packet_status;
        logic [7:0] packet_dx;
        logic [7:0] packet_dy;
        logic       flush_request;
        logic       initialised;
        logic       four_byte_mode;
    } t_result;

    // Init scripts: plain and wheel knock sequence
    function automatic logic [7:0] script_table(input logic wheel, input logic [PTR_W-1:0] p);
        logic [7:0] e;
        e = ENTRY_END;
        if (wheel) begin
            case (p)
                5'd0:    e = SEND_ONE;
                5'd1:    e = CMD_RESET;
                5'd2:    e = AWAIT_TWO;
                5'd3:    e = SEND_KNOCK;
                5'd4:    e = CMD_SET_RATE;
                5'd5:    e = RATE_200;
                5'd6:    e = CMD_SET_RATE;
                5'd7:    e = RATE_100;
                5'd8:    e = CMD_SET_RATE;
                5'd9:    e = RATE_80;
                5'd10:   e = CMD_GET_ID;
                5'd11:   e = AWAIT_ONE;
                5'd12:   e = SEND_ONE;
                5'd13:   e = CMD_ENABLE;
                default: e = ENTRY_END;
            endcase
        end else begin
            case (p)
                5'd0:    e = SEND_ONE;
                5'd1:    e = CMD_RESET;
                5'd2:    e = AWAIT_TWO;
                5'd3:    e = SEND_ONE;
                5'd4:    e = CMD_ENABLE;
                default: e = ENTRY_END;
            endcase
        end
        return e;
    endfunction

    // Turn a script entry into send / await counts; a zero count ends the script
    function automatic t_load decode_entry(input logic [7:0] e);
        t_load l;
        l.phase = PH_SCRIPT;
        if (e[7]) begin
            l.awt  = e[AWAIT_W-1:0];
            l.send = '0;
            if (l.awt == '0) begin
                l.phase = PH_RUN;
            end
        end else begin
            l.send = e[SEND_W-1:0];
            l.awt  = '0;
            if (l.send == '0) begin
                l.phase = PH_RUN;
            end
        end
        return l;
    endfunction

endpackage

FILE: rtl/core/ps2_mouse_init_and_packet_assembler.sv
// PS/2 mouse host controller: init script walker and packet assembler.
// A result is registered in the output register, or in the skid register if stalled.
// Throughput: one item per cycle while o_in_stall is low; the whole state update is
// one combinational pass into the state and output registers, with a skid stage on the output.
// Reset (synchronous, active low) restores register defaults and restarts the script.
module ps2_mouse_init_and_packet_assembler #(
    parameter int SCRIPT_DEPTH = ps2m_pkg::SCRIPT_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write port
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [ps2m_pkg::CFG_W-1:0]  i_cfg_data,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_opcode,
    input  logic [7:0]                  i_rx_byte,
    // output channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_tx_valid,
    output logic [7:0]                  o_tx_byte,
    output logic                        o_packet_valid,
    output logic [7:0]                  o_packet_status,
    output logic [7:0]                  o_packet_dx,
    output logic [7:0]                  o_packet_dy,
    output logic                        o_flush_request,
    output logic                        o_initialised,
    output logic                        o_four_byte_mode
);

    localparam int unsigned PTR_W   = ps2m_pkg::PTR_W;
    localparam int unsigned SEND_W  = ps2m_pkg::SEND_W;
    localparam int unsigned AWAIT_W = ps2m_pkg::AWAIT_W;
    localparam int unsigned TIMER_W = ps2m_pkg::TIMER_W;
    localparam int unsigned PIDX_W  = ps2m_pkg::PIDX_W;

    // configuration
    logic               r_wheel;
    logic [TIMER_W-1:0] r_init_to;
    logic [TIMER_W-1:0] r_pkt_to;

    // state
    ps2m_pkg::t_phase   r_phase,  n_phase;
    logic [PTR_W-1:0]   r_ptr,    n_ptr;
    logic [SEND_W-1:0]  r_send,   n_send;
    logic [AWAIT_W-1:0] r_awt,    n_awt;
    logic [TIMER_W-1:0] r_timer,  n_timer;
    logic [PIDX_W-1:0]  r_pidx,   n_pidx;
    logic               r_len4,   n_len4;
    logic [7:0]         r_pkt_store [3];
    logic [7:0]         n_pkt_store [3];

    // output stage
    ps2m_pkg::t_result  n_res, r_out, r_skid;
    logic               r_out_valid, r_skid_valid;

    logic               in_xfer;
    logic               out_xfer;

    assign o_in_stall = r_skid_valid;
    assign in_xfer    = i_in_valid && !r_skid_valid;
    assign out_xfer   = r_out_valid && !i_out_stall;

    // Script entry read, ending the script at or past the depth
    function automatic logic [7:0] fetch(input logic wheel, input logic [PTR_W-1:0] p);
        logic [7:0] e;
        e = ps2m_pkg::ENTRY_END;
        if (int'(p) < SCRIPT_DEPTH) begin
            e = ps2m_pkg::script_table(wheel, p);
        end
        return e;
    endfunction

    // Step the controller for one event
    always_comb begin
        logic [7:0]        e;
        ps2m_pkg::t_load   ld;
        ps2m_pkg::t_opcode op;

        n_phase     = r_phase;
        n_ptr       = r_ptr;
        n_send      = r_send;
        n_awt       = r_awt;
        n_timer     = r_timer;
        n_pidx      = r_pidx;
        n_len4      = r_len4;
        n_pkt_store = r_pkt_store;
        n_res       = '0;
        e           = '0;
        ld          = '0;
        op          = ps2m_pkg::t_opcode'(i_opcode);

        if (op != ps2m_pkg::OP_IGNORED) begin
            if (op == ps2m_pkg::OP_RESTART) begin
                n_phase = ps2m_pkg::PH_START;
            end

            case (n_phase)
                ps2m_pkg::PH_SCRIPT: begin
                    if (n_awt == '0 && n_send != '0) begin
                        // send the next command byte, expect one acknowledge
                        e                = fetch(r_wheel, n_ptr);
                        n_ptr            = n_ptr + 1'b1;
                        n_res.tx_valid   = 1'b1;
                        n_res.tx_byte    = e;
                        n_send           = n_send - 1'b1;
                        n_awt            = AWAIT_W'(1);
                        n_timer          = r_init_to;
                        if (op == ps2m_pkg::OP_BYTE) begin
                            // byte during pending send counts as its acknowledge
                            n_awt = '0;
                            if (n_send == '0) begin
                                ld      = ps2m_pkg::decode_entry(fetch(r_wheel, n_ptr));
                                n_ptr   = n_ptr + 1'b1;
                                n_phase = ld.phase;
                                n_send  = ld.send;
                                n_awt   = ld.awt;
                            end
                        end
                    end else if (n_awt != '0) begin
                        if (op == ps2m_pkg::OP_BYTE) begin
                            n_awt = n_awt - 1'b1;
                            if (n_awt == '0 && n_send == '0) begin
                                ld      = ps2m_pkg::decode_entry(fetch(r_wheel, n_ptr));
                                n_ptr   = n_ptr + 1'b1;
                                n_phase = ld.phase;
                                n_send  = ld.send;
                                n_awt   = ld.awt;
                            end
                        end else begin
                            // count down; restart and flush on timeout
                            if (n_timer != '0) begin
                                n_timer = n_timer - 1'b1;
                            end
                            if (n_timer == '0) begin
                                n_res.flush_request = 1'b1;
                                n_phase             = ps2m_pkg::PH_START;
                            end
                        end
                    end else begin
                        n_phase = ps2m_pkg::PH_RUN;
                    end
                end

                ps2m_pkg::PH_RUN: begin
                    if (op == ps2m_pkg::OP_TICK) begin
                        if (n_timer != '0) begin
                            n_timer = n_timer - 1'b1;
                        end
                    end else begin
                        // stale partial packet: toggle length and drop it
                        if (n_pidx != '0 && n_timer == '0) begin
                            n_len4 = ~n_len4;
                            n_pidx = '0;
                        end
                        if (n_pidx < PIDX_W'(3)) begin
                            n_pkt_store[n_pidx[1:0]] = i_rx_byte;
                        end
                        n_pidx = n_pidx + 1'b1;
                        if (n_pidx >= (n_len4 ? PIDX_W'(4) : PIDX_W'(3))) begin
                            n_res.packet_valid  = 1'b1;
                            n_res.packet_status = n_pkt_store[0];
                            n_res.packet_dx     = n_pkt_store[1];
                            n_res.packet_dy     = n_pkt_store[2];
                            n_pidx              = '0;
                        end
                        n_timer = r_pkt_to;
                    end
                end

                default: begin
                    // start: load the first entry, drop any carried byte
                    ld      = ps2m_pkg::decode_entry(fetch(r_wheel, '0));
                    n_ptr   = PTR_W'(1);
                    n_phase = ld.phase;
                    n_send  = ld.send;
                    n_awt   = ld.awt;
                end
            endcase
        end

        n_res.initialised    = (n_phase == ps2m_pkg::PH_RUN);
        n_res.four_byte_mode = n_len4;
    end

    // Configuration registers and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel   <= 1'b1;
            r_init_to <= ps2m_pkg::INIT_TIMEOUT_RST;
            r_pkt_to  <= ps2m_pkg::PACKET_TIMEOUT_RST;
            r_phase   <= ps2m_pkg::PH_START;
            r_ptr     <= '0;
            r_send    <= '0;
            r_awt     <= '0;
            r_timer   <= '0;
            r_pidx    <= '0;
            r_len4    <= 1'b1;
        end else begin
            if (in_xfer) begin
                r_phase <= n_phase;
                r_ptr   <= n_ptr;
                r_send  <= n_send;
                r_awt   <= n_awt;
                r_timer <= n_timer;
                r_pidx  <= n_pidx;
                r_len4  <= n_len4;
            end
            if (i_cfg_we) begin
                case (ps2m_pkg::t_cfg_index'(i_cfg_index))
                    ps2m_pkg::CFG_WHEEL_ENABLE: begin
                        r_wheel <= i_cfg_data[0];
                        r_len4  <= i_cfg_data[0];
                    end
                    ps2m_pkg::CFG_INIT_TIMEOUT: begin
                        r_init_to <= i_cfg_data;
                    end
                    ps2m_pkg::CFG_PACKET_TIMEOUT: begin
                        r_pkt_to <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Packet byte store
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_pkt_store <= n_pkt_store;
        end
    end

    // Output register and skid stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_xfer) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_xfer;
                end
            end else if (in_xfer) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Output and skid payload
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_xfer) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_xfer) begin
                r_out <= n_res;
            end
        end else if (in_xfer) begin
            r_skid <= n_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_tx_valid       = r_out.tx_valid;
    assign o_tx_byte        = r_out.tx_byte;
    assign o_packet_valid   = r_out.packet_valid;
    assign o_packet_status  = r_out.packet_status;
    assign o_packet_dx      = r_out.packet_dx;
    assign o_packet_dy      = r_out.packet_dy;
    assign o_flush_request  = r_out.flush_request;
    assign o_initialised    = r_out.initialised;
    assign o_four_byte_mode = r_out.four_byte_mode;

endmodule
